>>> rtl/core/terminated_frame_buffer_macros.svh
// Assertion macros for the frame buffer; define ASSERT_OFF to drop them.
`ifndef TERMINATED_FRAME_BUFFER_MACROS_SVH
`define TERMINATED_FRAME_BUFFER_MACROS_SVH

`ifndef ASSERT_OFF
`define TFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TFB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define TFB_ASSERT(lbl, prop, msg)
`define TFB_NEVER(lbl, expr, msg)
`endif

`endif

>>> rtl/core/tfb_pkg.sv
`default_nettype none

package tfb_pkg;

  localparam int BYTE_W        = 8;
  localparam int FRAME_LEN_W   = 5;
  localparam int TERM_LEN_W    = 3;
  localparam int EFF_LEN_W     = 4;
  localparam int NUM_TERM_REGS = 4;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 32;
  localparam int REG_IDX_W     = 3;

  localparam logic [REG_IDX_W-1:0] REG_TERM_LEN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TERM_B0  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TERM_B1  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TERM_B2  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TERM_B3  = 3'd4;

  localparam logic [TERM_LEN_W-1:0] TERM_LEN_RESET = 3'd1;
  localparam logic [BYTE_W-1:0]     TERM_B0_RESET  = 8'd10;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_SHOW
  } back_state_e;

endpackage

`default_nettype wire

>>> rtl/core/tfb_ram.sv
`default_nettype none

module tfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tfb_front.sv
`default_nettype none

`include "terminated_frame_buffer_macros.svh"

module tfb_front #(
  parameter int BUFFER_DEPTH          = 16,
  parameter int MAX_TERMINATOR_LENGTH = 4,
  localparam int IdxW = $clog2(BUFFER_DEPTH),
  localparam int CntW = $clog2(BUFFER_DEPTH + 1)
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       rx_valid_i,
  input  wire logic [tfb_pkg::BYTE_W-1:0]                 rx_byte_i,
  output logic                                            rx_ready_o,
  input  wire logic [tfb_pkg::TERM_LEN_W-1:0]             term_len_i,
  input  wire logic [MAX_TERMINATOR_LENGTH-1:0][tfb_pkg::BYTE_W-1:0] term_bytes_i,
  input  wire logic                                       cmd_full_i,
  output logic                                            wr_en_o,
  output logic      [IdxW:0]                              wr_addr_o,
  output logic      [tfb_pkg::BYTE_W-1:0]                 wr_data_o,
  output logic                                            push_o,
  output logic                                            push_bank_o,
  output logic      [CntW-1:0]                            push_len_o
);

  logic [CntW-1:0] fill_q, fill_d;
  logic            bank_q, bank_d;
  logic [MAX_TERMINATOR_LENGTH-1:0][tfb_pkg::BYTE_W-1:0] hist_q, tail;
  logic [tfb_pkg::EFF_LEN_W-1:0] eff_len;
  logic [CntW-1:0] cnt_next;
  logic            accept, term_hit, flush;

  assign rx_ready_o = !cmd_full_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign cnt_next   = fill_q + CntW'(1);

  always_comb begin
    if (int'(term_len_i) > MAX_TERMINATOR_LENGTH) begin
      eff_len = tfb_pkg::EFF_LEN_W'(MAX_TERMINATOR_LENGTH);
    end else begin
      eff_len = tfb_pkg::EFF_LEN_W'(term_len_i);
    end
  end

  // tail[j] is the byte j places back from the newest one
  always_comb begin
    tail[0] = rx_byte_i;
    for (int j = 1; j < MAX_TERMINATOR_LENGTH; j++) begin
      tail[j] = hist_q[j-1];
    end
  end

  always_comb begin
    term_hit = int'(cnt_next) >= int'(eff_len);
    for (int j = 0; j < MAX_TERMINATOR_LENGTH; j++) begin
      for (int k = 0; k < MAX_TERMINATOR_LENGTH; k++) begin
        if (j < int'(eff_len) && (j + k + 1) == int'(eff_len) &&
            tail[j] != term_bytes_i[k]) begin
          term_hit = 1'b0;
        end
      end
    end
  end

  assign flush = (int'(cnt_next) == BUFFER_DEPTH) || term_hit;

  assign wr_en_o     = accept;
  assign wr_addr_o   = {bank_q, fill_q[IdxW-1:0]};
  assign wr_data_o   = rx_byte_i;
  assign push_o      = accept && flush;
  assign push_bank_o = bank_q;
  assign push_len_o  = cnt_next;

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    if (accept) begin
      if (flush) begin
        fill_d = '0;
        bank_d = !bank_q;
      end else begin
        fill_d = cnt_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q <= tail;
    end
  end

  `TFB_NEVER(a_fill_below_depth, int'(fill_q) >= BUFFER_DEPTH, "fill count reached depth")
  `TFB_ASSERT(a_flush_empties, push_o |=> (fill_q == '0) && (bank_q != $past(bank_q)),
              "flush did not switch bank")

endmodule

`default_nettype wire

>>> rtl/core/tfb_cmd_fifo.sv
`default_nettype none

`include "terminated_frame_buffer_macros.svh"

module tfb_cmd_fifo #(
  parameter int WIDTH = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o,
  output logic                  valid_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o     = count_q == 2'd2;
  assign valid_o    = count_q != 2'd0;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TFB_NEVER(a_no_push_full, push_i && full_o, "push into full command queue")
  `TFB_NEVER(a_no_pop_empty, pop_i && !valid_o, "pop from empty command queue")

endmodule

`default_nettype wire

>>> rtl/core/tfb_back.sv
`default_nettype none

`include "terminated_frame_buffer_macros.svh"

module tfb_back #(
  parameter int BUFFER_DEPTH = 16,
  localparam int IdxW = $clog2(BUFFER_DEPTH),
  localparam int CntW = $clog2(BUFFER_DEPTH + 1)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cmd_valid_i,
  input  wire logic                                cmd_bank_i,
  input  wire logic [CntW-1:0]                     cmd_len_i,
  output logic                                     cmd_pop_o,
  output logic                                     rd_en_o,
  output logic      [IdxW:0]                       rd_addr_o,
  input  wire logic [tfb_pkg::BYTE_W-1:0]          rd_data_i,
  output logic                                     frame_valid_o,
  input  wire logic                                frame_ready_i,
  output logic      [tfb_pkg::BYTE_W-1:0]          frame_byte_o,
  output logic      [tfb_pkg::FRAME_LEN_W-1:0]     frame_length_o,
  output logic                                     last_of_frame_o
);

  tfb_pkg::back_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            last;

  assign last            = (CntW'(idx_q) + CntW'(1)) == cmd_len_i;
  assign frame_byte_o    = rd_data_i;
  assign frame_length_o  = tfb_pkg::FRAME_LEN_W'(cmd_len_i);
  assign last_of_frame_o = last;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tfb_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = tfb_pkg::BK_SHOW;
        end
      end
      tfb_pkg::BK_SHOW: begin
        if (frame_ready_i && last) begin
          state_d = tfb_pkg::BK_IDLE;
        end
      end
      default: state_d = tfb_pkg::BK_IDLE;
    endcase
  end

  // fetch the next byte as the current one is taken
  always_comb begin
    frame_valid_o = 1'b0;
    cmd_pop_o     = 1'b0;
    rd_en_o       = 1'b0;
    rd_addr_o     = {cmd_bank_i, idx_q};
    idx_d         = idx_q;
    case (state_q)
      tfb_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          rd_en_o   = 1'b1;
          rd_addr_o = {cmd_bank_i, {IdxW{1'b0}}};
          idx_d     = '0;
        end
      end
      tfb_pkg::BK_SHOW: begin
        frame_valid_o = 1'b1;
        if (frame_ready_i) begin
          if (last) begin
            cmd_pop_o = 1'b1;
          end else begin
            rd_en_o   = 1'b1;
            idx_d     = idx_q + IdxW'(1);
            rd_addr_o = {cmd_bank_i, idx_d};
          end
        end
      end
      default: begin
        frame_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfb_pkg::BK_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `TFB_ASSERT(a_show_has_cmd, frame_valid_o |-> cmd_valid_i, "replay without queued frame")
  `TFB_ASSERT(a_idx_in_frame, frame_valid_o |-> (CntW'(idx_q) < cmd_len_i),
              "replay index beyond frame length")

endmodule

`default_nettype wire

>>> rtl/core/terminated_frame_buffer.sv
// Terminator-delimited frame buffer. Received bytes (rx channel) are stored
// in one of two BUFFER_DEPTH-byte frame banks of one RAM; a frame ends when
// its last terminator_length bytes match the terminator registers, or when
// the bank fills, and is then replayed on the frame channel, one byte per
// cycle while frame_ready_i is high, each byte tagged with the frame length
// and the final byte flagged. An rx byte is taken every cycle while at most
// one finished frame awaits replay; with both banks waiting, rx stalls until
// the older frame's last byte goes out. Each frame's replay opens with a RAM
// read of its first byte from the idle state. APB registers: 0x00 terminator
// length (1..MAX_TERMINATOR_LENGTH, 0 flushes every byte), 0x04 to 0x10
// terminator bytes 0 to 3; write them only while the block is idle.
`default_nettype none

module terminated_frame_buffer #(
  parameter int BUFFER_DEPTH          = 16,
  parameter int MAX_TERMINATOR_LENGTH = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 rx_valid_i,
  output logic                                      rx_ready_o,
  input  wire logic [tfb_pkg::BYTE_W-1:0]           rx_byte_i,
  output logic                                      frame_valid_o,
  input  wire logic                                 frame_ready_i,
  output logic      [tfb_pkg::BYTE_W-1:0]           frame_byte_o,
  output logic      [tfb_pkg::FRAME_LEN_W-1:0]      frame_length_o,
  output logic                                      last_of_frame_o,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [tfb_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [tfb_pkg::APB_DATA_W-1:0]       pwdata,
  output logic      [tfb_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                      pready
);

  localparam int IdxW = $clog2(BUFFER_DEPTH);
  localparam int CntW = $clog2(BUFFER_DEPTH + 1);
  localparam int RamDepth = 2 << IdxW;

  logic [tfb_pkg::TERM_LEN_W-1:0]                 term_len_q;
  logic [tfb_pkg::NUM_TERM_REGS-1:0][tfb_pkg::BYTE_W-1:0] term_q;
  logic [MAX_TERMINATOR_LENGTH-1:0][tfb_pkg::BYTE_W-1:0]  term_eff;
  logic [tfb_pkg::REG_IDX_W-1:0]                  reg_idx;
  logic                                           cfg_wr;

  logic                    wr_en, rd_en;
  logic [IdxW:0]           wr_addr, rd_addr;
  logic [tfb_pkg::BYTE_W-1:0] wr_data, rd_data;
  logic                    cmd_full, cmd_push, cmd_pop, cmd_valid;
  logic                    push_bank;
  logic [CntW-1:0]         push_len;
  logic [CntW:0]           cmd_head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[tfb_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_len_q <= tfb_pkg::TERM_LEN_RESET;
      term_q     <= {{((tfb_pkg::NUM_TERM_REGS-1)*tfb_pkg::BYTE_W){1'b0}},
                     tfb_pkg::TERM_B0_RESET};
    end else if (cfg_wr) begin
      case (reg_idx)
        tfb_pkg::REG_TERM_LEN: term_len_q <= pwdata[tfb_pkg::TERM_LEN_W-1:0];
        tfb_pkg::REG_TERM_B0:  term_q[0]  <= pwdata[tfb_pkg::BYTE_W-1:0];
        tfb_pkg::REG_TERM_B1:  term_q[1]  <= pwdata[tfb_pkg::BYTE_W-1:0];
        tfb_pkg::REG_TERM_B2:  term_q[2]  <= pwdata[tfb_pkg::BYTE_W-1:0];
        tfb_pkg::REG_TERM_B3:  term_q[3]  <= pwdata[tfb_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tfb_pkg::REG_TERM_LEN: prdata = tfb_pkg::APB_DATA_W'(term_len_q);
      tfb_pkg::REG_TERM_B0:  prdata = tfb_pkg::APB_DATA_W'(term_q[0]);
      tfb_pkg::REG_TERM_B1:  prdata = tfb_pkg::APB_DATA_W'(term_q[1]);
      tfb_pkg::REG_TERM_B2:  prdata = tfb_pkg::APB_DATA_W'(term_q[2]);
      tfb_pkg::REG_TERM_B3:  prdata = tfb_pkg::APB_DATA_W'(term_q[3]);
      default:               prdata = '0;
    endcase
  end

  for (genvar k = 0; k < MAX_TERMINATOR_LENGTH; k++) begin : g_term
    if (k < tfb_pkg::NUM_TERM_REGS) begin : g_reg
      assign term_eff[k] = term_q[k];
    end else begin : g_zero
      assign term_eff[k] = '0;
    end
  end

  tfb_front #(
    .BUFFER_DEPTH          (BUFFER_DEPTH),
    .MAX_TERMINATOR_LENGTH (MAX_TERMINATOR_LENGTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_byte_i    (rx_byte_i),
    .rx_ready_o   (rx_ready_o),
    .term_len_i   (term_len_q),
    .term_bytes_i (term_eff),
    .cmd_full_i   (cmd_full),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .push_o       (cmd_push),
    .push_bank_o  (push_bank),
    .push_len_o   (push_len)
  );

  tfb_cmd_fifo #(
    .WIDTH (CntW + 1)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i ({push_bank, push_len}),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .pop_data_o  (cmd_head),
    .valid_o     (cmd_valid)
  );

  tfb_ram #(
    .WIDTH (tfb_pkg::BYTE_W),
    .DEPTH (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tfb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_bank_i      (cmd_head[CntW]),
    .cmd_len_i       (cmd_head[CntW-1:0]),
    .cmd_pop_o       (cmd_pop),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .frame_valid_o   (frame_valid_o),
    .frame_ready_i   (frame_ready_i),
    .frame_byte_o    (frame_byte_o),
    .frame_length_o  (frame_length_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

`default_nettype wire
